// File: src/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_BITS      = 24;
    localparam int IDX_W          = $clog2(NUM_PARTITIONS);
    localparam int CNT_W          = $clog2(NUM_PARTITIONS + 1);
    localparam int TAG_W          = 8;
    localparam int POLICY_W       = 2;
    localparam int IN_USE_W       = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITIONS_IN_USE = 1'b1;

    // Item function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [POLICY_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Outcome of one comparator step
    typedef struct packed {
        logic fits;    // entry free and large enough
        logic better;  // fits and beats the current pick under the policy
    } cmp_t;

endpackage

// File: src/fpfa_if.sv
// ----------------------------------------------------------------------------
// fpfa_req_if / fpfa_res_if
// Valid/ready channels for allocator items and their results.
// ----------------------------------------------------------------------------
interface fpfa_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic [3:0]                            entry_index;
    logic [fpfa_pkg::SIZE_BITS-1:0]        amount;
    logic [fpfa_pkg::TAG_W-1:0]            request_tag;

    modport source (output valid, func, entry_index, amount, request_tag, input ready);
    modport sink   (input valid, func, entry_index, amount, request_tag, output ready);
endinterface

interface fpfa_res_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  granted;
    logic [3:0]                            partition_index;
    logic [fpfa_pkg::TAG_W-1:0]            tag_out;

    modport source (output valid, granted, partition_index, tag_out, input ready);
    modport sink   (input valid, granted, partition_index, tag_out, output ready);
endinterface

// File: src/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best, worst and next fit allocation.
// ----------------------------------------------------------------------------
// Sequence: a load goes from idle straight to the finish state; a request first
//   scans the partitions in use (up to 16) before finishing. First and next fit
//   stop at the first hit. One comparator visits one partition a cycle.
// Items: a new item is accepted only in the idle state, so the last one must be
//   finished first; a finished item waits until the output register is free.
// Reset: asynchronous, active low; clears all sizes, taken marks, the next
//   fit pointer and the registers (policy first fit, 16 partitions in use).
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]      cfg_data,
    fpfa_req_if.sink                             req,
    fpfa_res_if.source                           res
);

    localparam int N = fpfa_pkg::NUM_PARTITIONS;

    // Configuration
    fpfa_pkg::fit_policy_t                 policy_reg;
    logic [fpfa_pkg::IN_USE_W-1:0]         in_use_reg;
    logic [fpfa_pkg::CNT_W-1:0]            n_eff;

    // Partition table
    logic [fpfa_pkg::SIZE_BITS-1:0]        size_reg [N];
    logic [N-1:0]                          taken_reg;
    logic [fpfa_pkg::IDX_W-1:0]            last_reg;

    // Sequencer
    fpfa_pkg::state_t                      state_reg, state_next;
    logic [fpfa_pkg::IDX_W-1:0]            pos_reg, pos_next;
    logic [fpfa_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic                                  pick_valid_reg, pick_valid_next;
    logic [fpfa_pkg::IDX_W-1:0]            pick_idx_reg, pick_idx_next;
    logic [fpfa_pkg::SIZE_BITS-1:0]        keep_reg, keep_next;
    logic [fpfa_pkg::SIZE_BITS-1:0]        want_reg;
    logic [fpfa_pkg::TAG_W-1:0]            tag_reg;
    logic                                  stg_granted_reg, stg_granted_next;
    logic [3:0]                            stg_idx_reg, stg_idx_next;

    // Output register
    logic                                  out_valid_reg, out_valid_next;
    logic                                  out_granted_reg;
    logic [3:0]                            out_idx_reg;
    logic [fpfa_pkg::TAG_W-1:0]            out_tag_reg;

    logic                                  accept;
    logic                                  is_load;
    logic                                  slot_free;
    logic                                  commit;
    logic [fpfa_pkg::CNT_W-1:0]            pos_inc;
    logic [fpfa_pkg::CNT_W-1:0]            last_ext;
    fpfa_pkg::cmp_t                        cmp;

    assign n_eff = (in_use_reg > fpfa_pkg::IN_USE_W'(N)) ? fpfa_pkg::CNT_W'(N)
                                                          : fpfa_pkg::CNT_W'(in_use_reg);

    assign req.ready   = (state_reg == fpfa_pkg::ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign is_load     = (req.func == fpfa_pkg::FUNC_LOAD);
    assign slot_free   = !out_valid_reg || res.ready;
    assign pos_inc     = fpfa_pkg::CNT_W'(pos_reg) + fpfa_pkg::CNT_W'(1);
    assign last_ext    = fpfa_pkg::CNT_W'(last_reg);

    assign res.valid           = out_valid_reg;
    assign res.granted         = out_granted_reg;
    assign res.partition_index = out_idx_reg;
    assign res.tag_out         = out_tag_reg;

    // Compare the visited partition
    fpfa_cmp u_cmp (
        .policy     (policy_reg),
        .taken      (taken_reg[pos_reg]),
        .size       (size_reg[pos_reg]),
        .want       (want_reg),
        .pick_valid (pick_valid_reg),
        .keep_size  (keep_reg),
        .result     (cmp)
    );

    // Sequence the scan and stage the result
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        pick_valid_next  = pick_valid_reg;
        pick_idx_next    = pick_idx_reg;
        keep_next        = keep_reg;
        stg_granted_next = stg_granted_reg;
        stg_idx_next     = stg_idx_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        commit           = 1'b0;

        unique case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pick_valid_next  = 1'b0;
                    cnt_next         = n_eff;
                    stg_granted_next = 1'b0;
                    stg_idx_next     = is_load ? req.entry_index : 4'd0;
                    if (policy_reg == fpfa_pkg::FIT_NEXT && last_ext < n_eff)
                        pos_next = last_reg;
                    else
                        pos_next = '0;
                    if (is_load || n_eff == '0)
                        state_next = fpfa_pkg::ST_FINISH;
                    else
                        state_next = fpfa_pkg::ST_SCAN;
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                if (cmp.better)
                begin
                    pick_valid_next = 1'b1;
                    pick_idx_next   = pos_reg;
                    keep_next       = size_reg[pos_reg];
                end
                // Advance with wrap at the end of the range
                pos_next = (pos_inc == n_eff) ? '0 : pos_inc[fpfa_pkg::IDX_W-1:0];
                cnt_next = cnt_reg - fpfa_pkg::CNT_W'(1);
                if (cnt_reg == fpfa_pkg::CNT_W'(1) || pick_valid_next &&
                    (policy_reg == fpfa_pkg::FIT_FIRST || policy_reg == fpfa_pkg::FIT_NEXT))
                begin
                    commit           = pick_valid_next;
                    stg_granted_next = pick_valid_next;
                    stg_idx_next     = pick_valid_next ? 4'(pick_idx_next) : 4'd0;
                    state_next       = fpfa_pkg::ST_FINISH;
                end
            end
            fpfa_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = fpfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpfa_pkg::ST_IDLE;
            cnt_reg         <= '0;
            pick_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            policy_reg      <= fpfa_pkg::FIT_FIRST;
            in_use_reg      <= fpfa_pkg::IN_USE_W'(16);
            last_reg        <= '0;
            taken_reg       <= '0;
            for (int i = 0; i < N; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pick_valid_reg <= pick_valid_next;
            out_valid_reg  <= out_valid_next;

            // Write configuration
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpfa_pkg::CFG_FIT_POLICY:
                        policy_reg <= fpfa_pkg::fit_policy_t'(cfg_data[fpfa_pkg::POLICY_W-1:0]);
                    fpfa_pkg::CFG_PARTITIONS_IN_USE:
                        in_use_reg <= cfg_data[fpfa_pkg::IN_USE_W-1:0];
                    default: ;
                endcase
            end

            // Load a partition and free it
            if (accept && is_load)
            begin
                size_reg[req.entry_index[fpfa_pkg::IDX_W-1:0]]  <= req.amount;
                taken_reg[req.entry_index[fpfa_pkg::IDX_W-1:0]] <= 1'b0;
            end

            // Mark the granted partition
            if (commit)
            begin
                taken_reg[pick_idx_next] <= 1'b1;
                if (policy_reg == fpfa_pkg::FIT_NEXT)
                    last_reg <= pick_idx_next;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        pick_idx_reg    <= pick_idx_next;
        keep_reg        <= keep_next;
        stg_granted_reg <= stg_granted_next;
        stg_idx_reg     <= stg_idx_next;
        if (accept)
        begin
            want_reg <= req.amount;
            tag_reg  <= req.request_tag;
        end
        if (state_reg == fpfa_pkg::ST_FINISH && slot_free)
        begin
            out_granted_reg <= stg_granted_reg;
            out_idx_reg     <= stg_idx_reg;
            out_tag_reg     <= tag_reg;
        end
    end

    // Check sequencer invariants
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpfa_pkg::ST_SCAN |-> cnt_reg != '0)
        else $error("scan running with no partitions left");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != fpfa_pkg::ST_IDLE)
        else $error("sequencer stayed idle after an accepted transaction");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> taken_reg[$past(pick_idx_next)])
        else $error("granted partition not marked taken");

    a_out_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == fpfa_pkg::ST_FINISH)
        else $error("result presented without a finished transaction");

endmodule

// File: src/fpfa_cmp.sv
// ----------------------------------------------------------------------------
// fpfa_cmp
// Shared compare unit: checks one partition against the request and the
// current best pick.
// ----------------------------------------------------------------------------
module fpfa_cmp (
    input  fpfa_pkg::fit_policy_t           policy,
    input  logic                            taken,
    input  logic [fpfa_pkg::SIZE_BITS-1:0]  size,
    input  logic [fpfa_pkg::SIZE_BITS-1:0]  want,
    input  logic                            pick_valid,
    input  logic [fpfa_pkg::SIZE_BITS-1:0]  keep_size,
    output fpfa_pkg::cmp_t                  result
);

    logic fit;
    logic smaller;
    logic larger;

    // Leftover order equals size order for the same request
    assign fit     = !taken && (size >= want);
    assign smaller = size < keep_size;
    assign larger  = size > keep_size;

    always_comb
    begin
        result.fits = fit;
        unique case (policy)
            fpfa_pkg::FIT_BEST:  result.better = fit && (!pick_valid || smaller);
            fpfa_pkg::FIT_WORST: result.better = fit && (!pick_valid || larger);
            default:             result.better = fit && !pick_valid;
        endcase
    end

endmodule
